// ===== rtl/smm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented memory manager package
// Request kinds, status codes and the word passed from front to back end.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_STORE  = 3'd1;
    localparam logic [2:0] REQ_MAP    = 3'd2;
    localparam logic [2:0] REQ_UNMAP  = 3'd3;
    localparam logic [2:0] REQ_DUP    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNMAPPED = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NO_ID    = 3'd3;
    localparam logic [2:0] ST_SIZE     = 3'd4;

    // Operations the back end carries out on the word store.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    localparam int SEG_COUNT = 64;
    localparam int SEG_WORDS = 1024;

    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;
    localparam int SEG_W  = 6;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [1:0]        op;
        logic              copy;      // fill from source segment instead of zero
        logic [SEG_W-1:0]  dst;
        logic [SEG_W-1:0]  src;
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  count;
        logic [DATA_W-1:0] wdata;
        logic [SEG_W-1:0]  new_segment;
        logic [2:0]        status;
    } cmd_t;

endpackage

// ===== rtl/smm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented memory manager front end
// Checks each request against the segment table, updates the table and the
// free ID queue, and issues one command word for the back end.
// ----------------------------------------------------------------------------
module smm_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [5:0]         segment,
    input  logic [9:0]         word_index,
    input  logic [31:0]        write_value,
    input  logic [10:0]        map_size,
    input  logic [5:0]         source_segment,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output smm_pkg::cmd_t      cmd
);
    import smm_pkg::*;

    localparam int NSEG = SEG_COUNT;

    logic [LEN_W-1:0] len_mem [NSEG];
    logic [NSEG-1:0]  mapped_reg;
    logic [SEG_W-1:0] fifo_mem [NSEG];
    logic [SEG_W-1:0] head_reg;
    logic [SEG_W:0]   count_reg;
    logic [SEG_W:0]   fresh_reg;

    // The request is held here while the table reads complete.
    logic              busy_reg;
    logic [2:0]        kind_reg;
    logic [SEG_W-1:0]  seg_reg, src_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] wval_reg;
    logic [LEN_W-1:0]  size_reg;
    logic [LEN_W-1:0]  seg_len_reg, src_len_reg;
    logic [SEG_W-1:0]  head_id_reg;

    logic        take, issue;
    logic        seg_live, src_live, have_id;
    logic [SEG_W-1:0] id_pick, tail;
    cmd_t        c;

    assign in_ready = !busy_reg;
    assign take = in_valid && !busy_reg;
    assign cmd_valid = busy_reg;
    assign issue = busy_reg && cmd_ready;
    assign seg_live = mapped_reg[seg_reg];
    assign src_live = mapped_reg[src_reg];
    assign have_id = (count_reg != '0) || (fresh_reg < (SEG_W+1)'(NSEG));
    assign id_pick = (count_reg != '0) ? head_id_reg : fresh_reg[SEG_W-1:0];
    assign tail = head_reg + count_reg[SEG_W-1:0];

    always_comb begin
        c = '0;
        c.dst = seg_reg;
        c.src = src_reg;
        c.index = idx_reg;
        c.wdata = wval_reg;
        c.status = ST_OK;
        case (kind_reg)
            REQ_LOAD, REQ_STORE: begin
                if (!seg_live) begin
                    c.status = ST_UNMAPPED;
                end else if ({1'b0, idx_reg} >= seg_len_reg) begin
                    c.status = ST_RANGE;
                end else begin
                    c.op = (kind_reg == REQ_LOAD) ? OP_LOAD : OP_STORE;
                end
            end
            REQ_MAP: begin
                if (size_reg > LEN_W'(SEG_WORDS)) begin
                    c.status = ST_SIZE;
                end else if (!have_id) begin
                    c.status = ST_NO_ID;
                end else begin
                    c.op = OP_FILL;
                    c.dst = id_pick;
                    c.count = size_reg;
                    c.new_segment = id_pick;
                end
            end
            REQ_UNMAP: begin
                if (!seg_live) c.status = ST_UNMAPPED;
            end
            REQ_DUP: begin
                if (seg_reg != src_reg) begin
                    if (!seg_live || !src_live) begin
                        c.status = ST_UNMAPPED;
                    end else begin
                        c.op = OP_FILL;
                        c.copy = 1'b1;
                        c.count = src_len_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign cmd = c;

    // Table reads are taken at the accepting edge; the previous request has
    // already updated the tables by then, since only one request is held.
    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= req_type;
            seg_reg <= segment;
            src_reg <= source_segment;
            idx_reg <= word_index;
            wval_reg <= write_value;
            size_reg <= map_size;
            seg_len_reg <= len_mem[segment];
            src_len_reg <= len_mem[source_segment];
            head_id_reg <= fifo_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mapped_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end else begin
            if (take) begin
                busy_reg <= 1'b1;
            end else if (issue) begin
                busy_reg <= 1'b0;
            end
            if (issue) begin
                if (kind_reg == REQ_MAP && c.op == OP_FILL) begin
                    mapped_reg[id_pick] <= 1'b1;
                    if (count_reg != '0) begin
                        head_reg <= head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end else begin
                        fresh_reg <= fresh_reg + 1'b1;
                    end
                end else if (kind_reg == REQ_UNMAP && seg_live) begin
                    mapped_reg[seg_reg] <= 1'b0;
                    if (count_reg < (SEG_W+1)'(NSEG)) count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // A length is only read while its segment is mapped, so no reset is needed.
    always_ff @(posedge aclk) begin
        if (issue && kind_reg == REQ_MAP && c.op == OP_FILL) begin
            len_mem[id_pick] <= size_reg;
        end else if (issue && kind_reg == REQ_DUP && c.op == OP_FILL) begin
            len_mem[seg_reg] <= src_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && kind_reg == REQ_UNMAP && seg_live && count_reg < (SEG_W+1)'(NSEG)) begin
            fifo_mem[tail] <= seg_reg;
        end
    end

endmodule

// ===== rtl/smm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented memory manager command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module smm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  smm_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output smm_pkg::cmd_t out_cmd
);
    import smm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end

endmodule

// ===== rtl/smm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented memory manager back end
// Owns the word store. Loads and stores take one access; fill and copy sweep
// the segment one word a cycle. Results leave through an output register.
// ----------------------------------------------------------------------------
module smm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  smm_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [31:0]   res_read_data,
    output logic [5:0]    res_new_segment,
    output logic [2:0]    res_status
);
    import smm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [31:0] mem [SEG_COUNT*SEG_WORDS];
    logic [1:0]  state_reg;
    cmd_t        cur_reg;
    logic [LEN_W-1:0] pos_reg;
    logic [31:0] rd_reg;
    logic        rdv_reg;        // a copy read is in flight for pos_reg
    logic        out_full_reg;
    logic [31:0] out_data_reg;
    logic [5:0]  out_seg_reg;
    logic [2:0]  out_st_reg;

    logic out_free, issue, wr_en, rd_en;
    logic [15:0] wr_addr, rd_addr;
    logic [31:0] wr_data;
    logic [LEN_W-1:0] rd_pos;

    assign out_free = !out_full_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign issue = cmd_valid && cmd_ready;
    assign res_valid = out_full_reg;
    assign res_read_data = out_data_reg;
    assign res_new_segment = out_seg_reg;
    assign res_status = out_st_reg;
    assign rd_pos = rdv_reg ? pos_reg + 1'b1 : pos_reg;

    always_comb begin
        wr_en = 1'b0;
        wr_addr = {cur_reg.dst, pos_reg[IDX_W-1:0]};
        wr_data = '0;
        rd_en = 1'b0;
        rd_addr = {cmd.dst, cmd.index};
        if (issue && cmd.op == OP_STORE) begin
            wr_en = 1'b1;
            wr_addr = {cmd.dst, cmd.index};
            wr_data = cmd.wdata;
        end else if (issue && cmd.op == OP_LOAD) begin
            rd_en = 1'b1;
        end else if (state_reg == S_COPY) begin
            if (!cur_reg.copy) begin
                wr_en = (pos_reg < cur_reg.count);
            end else begin
                wr_en = rdv_reg;
                wr_data = rd_reg;
                rd_en = (rd_pos < cur_reg.count);
                rd_addr = {cur_reg.src, rd_pos[IDX_W-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_full_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) out_full_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (issue) begin
                        cur_reg <= cmd;
                        pos_reg <= '0;
                        rdv_reg <= 1'b0;
                        if (cmd.op == OP_LOAD) begin
                            state_reg <= S_READ;
                        end else if (cmd.op == OP_FILL) begin
                            state_reg <= S_COPY;
                        end else begin
                            out_full_reg <= 1'b1;
                            out_data_reg <= '0;
                            out_seg_reg <= cmd.new_segment;
                            out_st_reg <= cmd.status;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_DONE;
                end
                S_COPY: begin
                    // Copy pipeline: read at rd_pos, write the word read last cycle.
                    if (cur_reg.copy) begin
                        rdv_reg <= rd_en;
                        if (rdv_reg) pos_reg <= pos_reg + 1'b1;
                        if (!rd_en && !rdv_reg) state_reg <= S_DONE;
                    end else if (pos_reg < cur_reg.count) begin
                        pos_reg <= pos_reg + 1'b1;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_full_reg <= 1'b1;
                        out_data_reg <= (cur_reg.op == OP_LOAD) ? rd_reg : '0;
                        out_seg_reg <= cur_reg.new_segment;
                        out_st_reg <= cur_reg.status;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/segmented_memory_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented memory manager
// Up to 64 segments of up to 1024 words with recycled segment IDs.
// ----------------------------------------------------------------------------
// The front end reads the segment table at the edge that accepts a request and
// offers the checked command from registers in the following cycle, holding it
// until the queue takes it, so it takes no new request while one is held. A
// two-word queue lets it run ahead of the back end. In the back end a store or a
// rejected request goes straight to the output register, while a load passes
// through the S_READ and S_DONE states, owing to the registered read port of the
// word store. Map zero-fills and duplicate copies one word a cycle in S_COPY.
// Every request returns exactly one result word with a status code.
module segmented_memory_manager_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // req_type
    // segment[5:0], word_index[15:6], write_value[47:16], map_size[58:48],
    // source_segment[64:59], zero fill to 72 bits
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], new_segment[37:32], status[40:38], zero fill to 48 bits
    output logic [47:0] m_tdata
);
    import smm_pkg::*;

    logic  f_valid, f_ready, q_valid, q_ready;
    cmd_t  f_cmd, q_cmd;
    logic [31:0] r_data;
    logic [5:0]  r_seg;
    logic [2:0]  r_st;

    smm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .req_type(s_tuser), .segment(s_tdata[5:0]), .word_index(s_tdata[15:6]),
        .write_value(s_tdata[47:16]), .map_size(s_tdata[58:48]),
        .source_segment(s_tdata[64:59]),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    smm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    smm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_read_data(r_data), .res_new_segment(r_seg), .res_status(r_st)
    );

    assign m_tdata = {7'd0, r_st, r_seg, r_data};

`ifndef ASSERT_OFF
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40:38] == ST_OK || m_tdata[40:38] == ST_UNMAPPED ||
                      m_tdata[40:38] == ST_RANGE || m_tdata[40:38] == ST_NO_ID ||
                      m_tdata[40:38] == ST_SIZE))
        else $error("bad status code");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[40:38] != ST_OK) |-> (m_tdata[37:0] == '0))
        else $error("failed request carries data");
    a_front_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted while a request was held");
`endif

endmodule
